FILE: src/arpt_pkg.sv
`timescale 1ns / 1ps
package arpt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HW_W        = 48;
  localparam int NET_W       = 8;
  localparam int PORT_W      = 8;
  localparam int DATA_W      = HW_W + PORT_W;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic REQ_LEARN  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // classified operation handed from front to back
  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   idx;
    logic [HW_W-1:0]    hw_addr;
    logic [PORT_W-1:0]  port_index;
  } op_t;

endpackage

FILE: src/arpt_req_if.sv
`timescale 1ns / 1ps
interface arpt_req_if;
  import arpt_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [NET_W-1:0]  net_addr;
  logic [HW_W-1:0]   hw_addr;
  logic [PORT_W-1:0] port_index;

  modport source (output valid, output req_type, output net_addr, output hw_addr,
                  output port_index, input ready);
  modport sink (input valid, input req_type, input net_addr, input hw_addr,
                input port_index, output ready);
endinterface

FILE: src/arpt_rsp_if.sv
`timescale 1ns / 1ps
interface arpt_rsp_if;
  import arpt_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [HW_W-1:0]   found_hw_addr;
  logic [PORT_W-1:0] found_port;

  modport source (output valid, output status, output found_hw_addr, output found_port,
                  input ready);
  modport sink (input valid, input status, input found_hw_addr, input found_port,
                output ready);
endinterface

FILE: src/address_resolution_table_core.sv
`timescale 1ns / 1ps
// an input transfer passes the queue, the s1 ram read stage and the output register before rsp
// throughput: one item per cycle while rsp is ready; the tag match in the front is
//   combinational, and the back reads or writes the data ram once per item
// a two-entry queue between front and back lets either side stall independently
// reset clears the entry count, the queue and the back pipeline; table contents are
//   not cleared and are only ever read below the entry count
module address_resolution_table_core (
  input  logic       clk,
  input  logic       rst,
  arpt_req_if.sink   req,
  arpt_rsp_if.source rsp
);
  import arpt_pkg::*;

  logic             push_valid;
  logic             push_ready;
  op_t              push_data;
  logic             pop_valid;
  logic             pop_ready;
  op_t              pop_data;
  logic [CNT_W-1:0] entry_count;

  arpt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data),
    .entry_count (entry_count)
  );

  arpt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  arpt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp       (rsp)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_ready && push_data.status == ST_INSERTED
    |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_ready && push_data.status == ST_FULL
    |-> entry_count == CNT_W'(TABLE_DEPTH))
    else $error("drop reported while room remains");

  a_zero_unless_hit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_HIT |-> rsp.found_hw_addr == '0 && rsp.found_port == '0)
    else $error("nonzero payload on a result that is not a hit");

endmodule

FILE: src/arpt_ram.sv
`timescale 1ns / 1ps
module arpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/arpt_queue.sv
`timescale 1ns / 1ps
module arpt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  arpt_pkg::op_t  wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output arpt_pkg::op_t  rd_data
);
  import arpt_pkg::*;

  op_t        slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = slot[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: src/arpt_front.sv
`timescale 1ns / 1ps
module arpt_front (
  input  logic                       clk,
  input  logic                       rst,
  arpt_req_if.sink                   req,
  output logic                       push_valid,
  input  logic                       push_ready,
  output arpt_pkg::op_t              push_data,
  output logic [arpt_pkg::CNT_W-1:0] entry_count
);
  import arpt_pkg::*;

  logic [NET_W-1:0]       tag [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;
  logic [IDX_W-1:0]       hit_idx;
  logic                   hit;
  logic                   full;
  logic                   take;
  status_t                cls;
  logic [IDX_W-1:0]       op_idx;

  assign req.ready  = push_ready;
  assign push_valid = req.valid;
  assign take       = req.valid && push_ready;
  assign full       = (entry_count == CNT_W'(TABLE_DEPTH));

  // addresses are unique in the table, so the matching index is an or of one-hot terms
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CNT_W'(i) < entry_count) && (tag[i] == req.net_addr);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    hit = |match;
  end

  always_comb begin
    op_idx = hit_idx;
    if (req.req_type == REQ_LOOKUP) begin
      cls = hit ? ST_HIT : ST_MISS;
    end else if (hit) begin
      cls = ST_UPDATED;
    end else if (!full) begin
      cls    = ST_INSERTED;
      op_idx = entry_count[IDX_W-1:0];
    end else begin
      cls = ST_FULL;
    end
  end

  assign push_data.status     = cls;
  assign push_data.idx        = op_idx;
  assign push_data.hw_addr    = req.hw_addr;
  assign push_data.port_index = req.port_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (take && cls == ST_INSERTED) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take && cls == ST_INSERTED) begin
      tag[entry_count[IDX_W-1:0]] <= req.net_addr;
    end
  end

endmodule

FILE: src/arpt_back.sv
`timescale 1ns / 1ps
module arpt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  arpt_pkg::op_t pop_data,
  arpt_rsp_if.source    rsp
);
  import arpt_pkg::*;

  logic              s1_valid;
  status_t           s1_status;
  logic              s1_adv;
  logic              pop;
  logic              ram_we;
  logic              ram_re;
  logic [DATA_W-1:0] ram_rdata;

  logic              out_valid;
  status_t           out_status;
  logic [HW_W-1:0]   out_hw;
  logic [PORT_W-1:0] out_port;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign pop_ready = !s1_valid || s1_adv;
  assign pop       = pop_valid && pop_ready;
  assign ram_we    = pop && (pop_data.status == ST_UPDATED || pop_data.status == ST_INSERTED);
  assign ram_re    = pop && (pop_data.status == ST_HIT);

  arpt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pop_data.idx),
    .wdata ({pop_data.hw_addr, pop_data.port_index}),
    .re    (ram_re),
    .raddr (pop_data.idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // read data holds while s1 stalls since the ram only reads on a pop
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_status <= pop_data.status;
    end
    if (s1_adv) begin
      out_status <= s1_status;
      if (s1_status == ST_HIT) begin
        out_hw   <= ram_rdata[DATA_W-1:PORT_W];
        out_port <= ram_rdata[PORT_W-1:0];
      end else begin
        out_hw   <= '0;
        out_port <= '0;
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.found_hw_addr = out_hw;
  assign rsp.found_port    = out_port;

endmodule

FILE: tb/address_resolution_table_core_tb.sv
`timescale 1ns / 1ps
module address_resolution_table_core_tb;
  import arpt_pkg::*;

  localparam int RANDOM_REQUESTS = 700;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;

  typedef struct {
    status_t           status;
    logic [HW_W-1:0]   hw_addr;
    logic [PORT_W-1:0] port;
  } reply_t;

  class arp_scoreboard;
    logic [NET_W-1:0]  known_net  [TABLE_DEPTH];
    logic [HW_W-1:0]   known_hw   [TABLE_DEPTH];
    logic [PORT_W-1:0] known_port [TABLE_DEPTH];
    int unsigned       filled;
    reply_t            pending_replies [$];
    int unsigned       tally [5];
    int unsigned       errors;

    function new();
      filled = 0;
      errors = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    // predicts the reply for an accepted request and updates the mirrored table
    function void note_request(logic kind, logic [NET_W-1:0] net, logic [HW_W-1:0] hw,
                               logic [PORT_W-1:0] port);
      reply_t r;
      int     slot;
      slot = -1;
      for (int i = 0; i < filled; i++) begin
        if (slot < 0 && known_net[i] == net) slot = i;
      end
      r.hw_addr = '0;
      r.port    = '0;
      if (kind == REQ_LOOKUP) begin
        if (slot >= 0) begin
          r.status  = ST_HIT;
          r.hw_addr = known_hw[slot];
          r.port    = known_port[slot];
        end else begin
          r.status = ST_MISS;
        end
      end else if (slot >= 0) begin
        known_hw[slot]   = hw;
        known_port[slot] = port;
        r.status         = ST_UPDATED;
      end else if (filled < TABLE_DEPTH) begin
        known_net[filled]  = net;
        known_hw[filled]   = hw;
        known_port[filled] = port;
        filled++;
        r.status = ST_INSERTED;
      end else begin
        r.status = ST_FULL;
      end
      tally[r.status]++;
      pending_replies.push_back(r);
    endfunction

    function void check_reply(status_t status, logic [HW_W-1:0] hw, logic [PORT_W-1:0] port);
      reply_t r;
      if (pending_replies.size() == 0) begin
        $error("reply with nothing pending: status %0d", status);
        errors++;
        return;
      end
      r = pending_replies.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        errors++;
      end
      if (hw !== r.hw_addr) begin
        $error("found_hw_addr: expected %h, got %h", r.hw_addr, hw);
        errors++;
      end
      if (port !== r.port) begin
        $error("found_port: expected %h, got %h", r.port, port);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;
  int unsigned cycle_count;
  arp_scoreboard arp_sb = new();

  arpt_req_if req();
  arpt_rsp_if rsp();

  address_resolution_table_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic issue(input logic kind, input logic [NET_W-1:0] net,
                       input logic [HW_W-1:0] hw, input logic [PORT_W-1:0] port);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.net_addr   <= net;
    req.hw_addr    <= hw;
    req.port_index <= port;
    do @(posedge clk); while (!req.ready);
    arp_sb.note_request(kind, net, hw, port);
  endtask

  task automatic issue_random();
    logic              kind;
    logic [NET_W-1:0]  net;
    logic [HW_W-1:0]   hw;
    logic [PORT_W-1:0] port;
    int                pick;
    kind = ($urandom_range(0, 99) < 45) ? REQ_LOOKUP : REQ_LEARN;
    pick = $urandom_range(0, 99);
    // mostly reuse learned addresses so lookups hit and learns refresh
    if (arp_sb.filled > 0 && pick < 60)
      net = arp_sb.known_net[$urandom_range(0, arp_sb.filled - 1)];
    else if (pick < 70)
      net = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
    else
      net = NET_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       hw = '0;
      1:       hw = '1;
      default: hw = HW_W'({$urandom(), $urandom()});
    endcase
    port = PORT_W'($urandom_range(0, 255));
    issue(kind, net, hw, port);
  endtask

  // reply side: random backpressure per transfer
  initial begin
    int gap;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      arp_sb.check_reply(rsp.status, rsp.found_hw_addr, rsp.found_port);
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    steady          = 1'b0;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.req_type   <= REQ_LEARN;
    req.net_addr   <= '0;
    req.hw_addr    <= '0;
    req.port_index <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty table, then inserts, refreshes, hits and misses at the field extremes
    issue(REQ_LOOKUP, 8'h00, '1, 8'hff);
    issue(REQ_LEARN,  8'h00, '0, 8'h00);
    issue(REQ_LEARN,  8'hff, '1, 8'hff);
    issue(REQ_LOOKUP, 8'h00, 48'h1234_5678_9abc, 8'h5a);
    issue(REQ_LOOKUP, 8'hff, '0, 8'h00);
    issue(REQ_LOOKUP, 8'h80, '0, 8'h00);
    issue(REQ_LEARN,  8'h00, 48'haaaa_aaaa_aaaa, 8'h55);
    issue(REQ_LOOKUP, 8'h00, '0, 8'h00);
    issue(REQ_LEARN,  8'hff, 48'h5555_5555_5555, 8'haa);
    issue(REQ_LOOKUP, 8'hff, '0, 8'h00);
    issue(REQ_LEARN,  8'h7f, 48'h0000_0000_0001, 8'h01);
    issue(REQ_LEARN,  8'h80, 48'h8000_0000_0000, 8'h80);
    issue(REQ_LOOKUP, 8'h7f, '1, 8'hff);
    issue(REQ_LOOKUP, 8'h80, '1, 8'hff);
    issue(REQ_LOOKUP, 8'h01, '0, 8'h00);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      issue_random();
    end
    req.valid <= 1'b0;

    while (arp_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d hits, %0d misses, %0d refreshes, %0d inserts, %0d drops on a full table",
             arp_sb.tally[ST_HIT], arp_sb.tally[ST_MISS], arp_sb.tally[ST_UPDATED],
             arp_sb.tally[ST_INSERTED], arp_sb.tally[ST_FULL]);
    if (arp_sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
